FILE: hdl/tgp_pkg.sv
// Shared constants, register indexes and the font lookup for the text glyph placer.
// No dependencies; imported by text_glyph_placer_unit.
package tgp_pkg;

	localparam int GLYPH_WIDTH_DEF = 5;
	localparam int LINE_PITCH_DEF  = 10;

	localparam logic [7:0] ESC_BYTE     = 8'hFF;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [6:0] SPACE_GLYPH  = 7'd70;
	localparam logic [7:0] COUNT_MAX    = 8'd255;
	localparam logic [7:0] TINT_WHITE   = 8'hFF;

	localparam logic [0:0] REG_ANCHOR_X = 1'b0;
	localparam logic [0:0] REG_ANCHOR_Y = 1'b1;

	localparam int CHAR_W  = 8;
	localparam int GLYPH_W = 7;
	localparam int COORD_W = 17;
	localparam int ANCHOR_W = 16;
	localparam int TINT_W  = 8;
	localparam int OUT_DATA_W = 72;

	// Maps a text byte to its font slot; anything unlisted takes the space glyph.
	function automatic logic [6:0] glyph_of(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'd0;
		glyph_of = SPACE_GLYPH;
		case (ch) inside
			[8'h41:8'h5A]: begin
				d = ch - 8'h41;
				glyph_of = d[6:0];
			end
			[8'h61:8'h7A]: begin
				d = ch - 8'h61 + 8'd26;
				glyph_of = d[6:0];
			end
			[8'h31:8'h39]: begin
				d = ch - 8'h31 + 8'd52;
				glyph_of = d[6:0];
			end
			8'h30: glyph_of = 7'd61;
			8'h28: glyph_of = 7'd62;
			8'h29: glyph_of = 7'd63;
			8'h5B: glyph_of = 7'd64;
			8'h5D: glyph_of = 7'd65;
			8'h7B: glyph_of = 7'd66;
			8'h7D: glyph_of = 7'd67;
			8'h3C: glyph_of = 7'd68;
			8'h3E: glyph_of = 7'd69;
			8'h20: glyph_of = 7'd70;
			8'h21: glyph_of = 7'd71;
			8'h2B: glyph_of = 7'd72;
			8'h2D: glyph_of = 7'd73;
			8'h2A: glyph_of = 7'd74;
			8'h3D: glyph_of = 7'd75;
			8'h3F: glyph_of = 7'd76;
			8'h2F: glyph_of = 7'd77;
			8'h5C: glyph_of = 7'd78;
			8'h2E: glyph_of = 7'd79;
			8'h2C: glyph_of = 7'd81;
			8'h3B: glyph_of = 7'd82;
			8'h3A: glyph_of = 7'd83;
			8'h22: glyph_of = 7'd84;
			8'h27: glyph_of = 7'd85;
			8'h7E: glyph_of = 7'd86;
			8'h60: glyph_of = 7'd87;
			8'h5E: glyph_of = 7'd88;
			8'h5F: glyph_of = 7'd89;
			8'h7C: glyph_of = 7'd90;
			8'h40: glyph_of = 7'd91;
			8'h23: glyph_of = 7'd92;
			8'h24: glyph_of = 7'd93;
			8'h25: glyph_of = 7'd94;
			8'h26: glyph_of = 7'd95;
			default: glyph_of = SPACE_GLYPH;
		endcase
	endfunction

endpackage

FILE: hdl/text_glyph_placer_unit.sv
// Text glyph placer: turns a byte stream into placed, tinted glyph words.
// Depends on tgp_pkg for constants and the font lookup.
//
// Usage:
//   Input stream s_*: one text byte per word in s_tdata, s_tuser[0] marks the
//   first byte of a text (clears column, line, escape and sets the tint to white
//   before that byte is handled). 0xFF opens a three byte color escape,
//   0x0A starts a new line; neither produces an output word.
//   Output stream m_*: one word per other byte (unlisted codes take the space
//   glyph), carrying glyph slot, destination x/y and the current tint.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write anchor_x (0) and anchor_y (1);
//   write only while the block is idle.
// Timing: one input word per cycle while s_tready is high; a result is registered
//   in the output or skid register. The text state and the output buffer are
//   updated in the same cycle, so the text state loop sets that rate.
// Reset (arst_n low): anchors zero, counters and escape cleared, tint white,
//   output empty.
// Stalls: a two-entry output buffer (output register plus skid register) keeps
//   s_tready high while one result waits; s_tready drops only when both hold
//   words, and rises again the cycle after the receiver takes one.
module text_glyph_placer_unit
	import tgp_pkg::*;
#(
	parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
	parameter int LINE_PITCH  = LINE_PITCH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] char_code
	input  logic [0:0]            s_tuser,   // [0] start_of_text
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [6:0] glyph_index, [23:7] dest_x, [40:24] dest_y, [48:41] tint_red,
	// [56:49] tint_green, [64:57] tint_blue, [71:65] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_addr,
	input  logic [ANCHOR_W-1:0]   cfg_wdata
);

	logic [ANCHOR_W-1:0] anchor_x_q, anchor_y_q;
	logic [7:0] col_q, line_q;
	logic [1:0] esc_q;
	logic [TINT_W-1:0] red_q, green_q, blue_q;

	logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;
	logic out_valid_q, skid_valid_q;

	logic accept, start, push, pop;
	logic [7:0] col_eff, line_eff;
	logic [1:0] esc_eff;
	logic [TINT_W-1:0] red_eff, green_eff, blue_eff;
	logic [7:0] col_nxt, line_nxt;
	logic [1:0] esc_nxt;
	logic [TINT_W-1:0] red_nxt, green_nxt, blue_nxt;
	logic [COORD_W-1:0] x_sum, y_sum;
	logic [OUT_DATA_W-1:0] res_word;

	assign accept = s_tvalid && s_tready;
	assign start  = s_tuser[0];
	assign pop    = m_tvalid && m_tready;

	// A start flag applies before the byte in the same word is handled.
	always_comb begin
		col_eff   = start ? 8'd0 : col_q;
		line_eff  = start ? 8'd0 : line_q;
		esc_eff   = start ? 2'd0 : esc_q;
		red_eff   = start ? TINT_WHITE : red_q;
		green_eff = start ? TINT_WHITE : green_q;
		blue_eff  = start ? TINT_WHITE : blue_q;

		col_nxt   = col_eff;
		line_nxt  = line_eff;
		esc_nxt   = esc_eff;
		red_nxt   = red_eff;
		green_nxt = green_eff;
		blue_nxt  = blue_eff;
		push      = 1'b0;

		if (esc_eff != 2'd0) begin
			case (esc_eff)
				2'd3:    red_nxt = s_tdata;
				2'd2:    green_nxt = s_tdata;
				default: blue_nxt = s_tdata;
			endcase
			esc_nxt = esc_eff - 2'd1;
		end else if (s_tdata == ESC_BYTE) begin
			esc_nxt = 2'd3;
		end else if (s_tdata == NEWLINE_BYTE) begin
			col_nxt = 8'd0;
			if (line_eff != COUNT_MAX) line_nxt = line_eff + 8'd1;
		end else begin
			push = accept;
			if (col_eff != COUNT_MAX) col_nxt = col_eff + 8'd1;
		end
	end

	assign x_sum = {anchor_x_q[ANCHOR_W-1], anchor_x_q}
		+ COORD_W'(GLYPH_WIDTH * int'(col_eff));
	assign y_sum = {anchor_y_q[ANCHOR_W-1], anchor_y_q}
		+ COORD_W'(LINE_PITCH * int'(line_eff));

	assign res_word = {7'd0, blue_eff, green_eff, red_eff, y_sum, x_sum, glyph_of(s_tdata)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ANCHOR_X: anchor_x_q <= cfg_wdata;
				REG_ANCHOR_Y: anchor_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			line_q  <= '0;
			esc_q   <= '0;
			red_q   <= TINT_WHITE;
			green_q <= TINT_WHITE;
			blue_q  <= TINT_WHITE;
		end else if (accept) begin
			col_q   <= col_nxt;
			line_q  <= line_nxt;
			esc_q   <= esc_nxt;
			red_q   <= red_nxt;
			green_q <= green_nxt;
			blue_q  <= blue_nxt;
		end
	end

	// Output register with one skid word behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_data_q <= skid_data_q;
		end else if (!out_valid_q || pop) begin
			if (push) out_data_q <= res_word;
		end else if (push) begin
			skid_data_q <= res_word;
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while output register is empty");

	a_escape_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !start && esc_q != 2'd0) |-> !push)
		else $error("escape byte produced a result");

	a_col_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !start && col_q == COUNT_MAX) |=> col_q == COUNT_MAX)
		else $error("column wrapped past its maximum");

	a_newline_clears_col: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && esc_eff == 2'd0 && s_tdata == NEWLINE_BYTE) |=> col_q == 8'd0)
		else $error("newline did not clear the column");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_glyph_placer_unit: drives text bytes and anchor writes,
// predicts every placed glyph word and checks it. Depends on tgp_pkg and the block only.
module tb;
	import tgp_pkg::*;

	typedef struct packed {
		logic [6:0]         glyph;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} placed_glyph_t;

	typedef enum {TEXT_PLAIN, TEXT_LONG_LINE, TEXT_MANY_LINES} text_kind_t;

	// Tracks the text state of the block and holds the glyph words still owed by it.
	class glyph_scoreboard;
		logic signed [15:0] anchor_x;
		logic signed [15:0] anchor_y;
		logic [7:0]         column;
		logic [7:0]         line_no;
		logic [1:0]         tint_bytes_left;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		placed_glyph_t      awaited[$];
		int                 errors;

		function new();
			anchor_x = '0;
			anchor_y = '0;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			column = '0;
			line_no = '0;
			tint_bytes_left = '0;
			red = TINT_WHITE;
			green = TINT_WHITE;
			blue = TINT_WHITE;
		endfunction

		function void set_anchor(logic [0:0] idx, logic [15:0] v);
			if (idx == REG_ANCHOR_X) begin
				anchor_x = v;
			end else begin
				anchor_y = v;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function logic [6:0] font_slot(logic [7:0] ch);
			// Slot 61 upward in order; the second period only fills slot 80, which
			// no character reaches, since the search stops at the first match.
			string punct = "0()[]{}<> !+-*=?/\\..,;:\"'~`^_|@#$%&";
			if (ch >= 8'h41 && ch <= 8'h5A) return 7'(ch - 8'h41);
			if (ch >= 8'h61 && ch <= 8'h7A) return 7'(ch - 8'h61 + 8'd26);
			if (ch >= 8'h31 && ch <= 8'h39) return 7'(ch - 8'h31 + 8'd52);
			for (int i = 0; i < punct.len(); i++) begin
				if (punct[i] == ch) return 7'(61 + i);
			end
			return SPACE_GLYPH;
		endfunction

		function void note_byte(logic [7:0] ch, logic sot);
			placed_glyph_t g;
			int px;
			int py;
			if (sot) clear_text();
			if (tint_bytes_left != 2'd0) begin
				case (tint_bytes_left)
					2'd3: red = ch;
					2'd2: green = ch;
					default: blue = ch;
				endcase
				tint_bytes_left = tint_bytes_left - 2'd1;
			end else if (ch == ESC_BYTE) begin
				tint_bytes_left = 2'd3;
			end else if (ch == NEWLINE_BYTE) begin
				column = '0;
				if (line_no != COUNT_MAX) line_no = line_no + 8'd1;
			end else begin
				px = int'(anchor_x) + GLYPH_WIDTH_DEF * int'(column);
				py = int'(anchor_y) + LINE_PITCH_DEF * int'(line_no);
				g.glyph = font_slot(ch);
				g.x = px[16:0];
				g.y = py[16:0];
				g.red = red;
				g.green = green;
				g.blue = blue;
				awaited.push_back(g);
				if (column != COUNT_MAX) column = column + 8'd1;
			end
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] w);
			placed_glyph_t want;
			placed_glyph_t got;
			if (awaited.size() == 0) begin
				$error("glyph word %h arrived with nothing awaited", w);
				errors++;
				return;
			end
			want = awaited.pop_front();
			got.glyph = w[6:0];
			got.x = w[23:7];
			got.y = w[40:24];
			got.red = w[48:41];
			got.green = w[56:49];
			got.blue = w[64:57];
			compare_field("glyph_index", want.glyph, got.glyph);
			compare_field("dest_x", want.x, got.x);
			compare_field("dest_y", want.y, got.y);
			compare_field("tint_red", want.red, got.red);
			compare_field("tint_green", want.green, got.green);
			compare_field("tint_blue", want.blue, got.blue);
			compare_field("padding", 0, w[71:65]);
		endfunction
	endclass

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 180;
	localparam int HOLD_CYCLES = 80;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CHAR_W-1:0]     s_tdata = '0;     // [7:0] char_code
	logic [0:0]            s_tuser = '0;     // [0] start_of_text
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [6:0] glyph_index, [23:7] dest_x, [40:24] dest_y, [48:41] tint_red,
	// [56:49] tint_green, [64:57] tint_blue, [71:65] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [0:0]            cfg_addr = '0;
	logic [ANCHOR_W-1:0]   cfg_wdata = '0;

	glyph_scoreboard sb = new;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;

	text_glyph_placer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Handshake signals only change at rising edges, so the falling edge sees
	// exactly what the next rising edge will accept.
	always @(negedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) sb.check_word(m_tdata);
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] ch, input logic sot);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= sot;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (s_tready === 1'b1);
			if (taken) sb.note_byte(ch, sot);
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// Escape and newline words leave nothing to wait for; give the pipe time.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_anchors(input logic [15:0] x, input logic [15:0] y);
		cfg_we <= 1'b1;
		cfg_addr <= REG_ANCHOR_X;
		cfg_wdata <= x;
		@(posedge clk);
		sb.set_anchor(REG_ANCHOR_X, x);
		cfg_addr <= REG_ANCHOR_Y;
		cfg_wdata <= y;
		@(posedge clk);
		sb.set_anchor(REG_ANCHOR_Y, y);
		cfg_we <= 1'b0;
	endtask

	// One text: a start word, then a long line, a run of newlines, or printable characters
	// mixed with newlines, color escapes, stray bytes, cut-off escapes and restarts.
	task automatic send_text(input text_kind_t kind);
		int n;
		int pick;
		send_byte(8'($urandom_range(126, 32)), 1'b1);
		if (kind == TEXT_LONG_LINE) begin
			repeat (262) send_byte(8'($urandom_range(126, 32)), 1'b0);
			send_byte(NEWLINE_BYTE, 1'b0);
			send_byte(8'h41, 1'b0);
		end else if (kind == TEXT_MANY_LINES) begin
			repeat (262) send_byte(NEWLINE_BYTE, 1'b0);
			repeat (3) send_byte(8'($urandom_range(126, 32)), 1'b0);
		end else begin
			n = $urandom_range(40, 1);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(99);
				if (pick < 62) begin
					send_byte(8'($urandom_range(126, 32)), 1'b0);
				end else if (pick < 72) begin
					send_byte(NEWLINE_BYTE, 1'b0);
				end else if (pick < 82) begin
					send_byte(ESC_BYTE, 1'b0);
					repeat (3) send_byte(8'($urandom_range(255)), 1'b0);
				end else if (pick < 87) begin
					send_byte(ESC_BYTE, 1'b0);
					repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
					send_byte(8'($urandom_range(255)), 1'b1);
				end else if (pick < 96) begin
					send_byte(8'($urandom_range(255)), 1'b0);
				end else begin
					send_byte(8'($urandom_range(255)), 1'b1);
				end
			end
		end
	endtask

	initial begin
		// {start_of_text, char_code}
		logic [8:0] directed[] = '{
			{1'b1, 8'h41}, {1'b0, 8'h5A}, {1'b0, 8'h61}, {1'b0, 8'h7A},
			{1'b0, 8'h31}, {1'b0, 8'h39}, {1'b0, 8'h30}, {1'b0, 8'h26},
			{1'b0, 8'h2C}, {1'b0, 8'h2E}, {1'b0, 8'h80}, {1'b0, 8'hFE},
			{1'b0, 8'h00}, {1'b0, 8'h7F}, {1'b0, 8'h0A}, {1'b0, 8'h78},
			{1'b0, 8'hFF}, {1'b0, 8'h0A}, {1'b0, 8'hFF}, {1'b0, 8'h00},
			{1'b0, 8'h71}, {1'b0, 8'hFF}, {1'b0, 8'h12}, {1'b1, 8'h42},
			{1'b1, 8'hFF}, {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03},
			{1'b0, 8'h43}
		};
		logic [15:0] ax_set[PHASES] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000,
			16'h7FFF};
		logic [15:0] ay_set[PHASES] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
			16'h8000};
		int phase_start;
		int seg;
		text_kind_t kind;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 15;
		recv_idle_pct = 45;
		@(posedge clk);

		// Anchors stay at their reset value for the directed words and phase 0.
		foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_for_drain();
				if (p == 4) write_anchors(16'($urandom), 16'($urandom));
				else write_anchors(ax_set[p], ay_set[p]);
			end
			send_idle_pct = (p < 2) ? 15 : (p < 4) ? 45 : 0;
			recv_idle_pct = (p < 2) ? 45 : (p < 4) ? 15 : 0;
			// The hold-off lets the output buffer fill so that s_tready drops.
			if (p == 1 || p == 4) hold_left = HOLD_CYCLES;
			phase_start = items_sent;
			seg = 0;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				kind = TEXT_PLAIN;
				if (seg == 0 && p == 0) kind = TEXT_LONG_LINE;
				if (seg == 0 && p == 2) kind = TEXT_MANY_LINES;
				send_text(kind);
				if (seg == 2 && p == 3) wait_for_drain();
				seg++;
			end
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tgp_pkg.sv
hdl/text_glyph_placer_unit.sv
bench/tb.sv
